/* rtl/core/ket_pkg.sv */
// Shared types and codes for the keyed event count table.
`default_nettype none

package ket_pkg;

   // Input item kinds
   localparam logic [1:0] KIND_RECORD = 2'd0;
   localparam logic [1:0] KIND_READ   = 2'd1;
   localparam logic [1:0] KIND_CLEAR  = 2'd2;

   // Result status codes
   localparam logic [2:0] STAT_UPDATED    = 3'd0;
   localparam logic [2:0] STAT_INSERTED   = 3'd1;
   localparam logic [2:0] STAT_FULL       = 3'd2;
   localparam logic [2:0] STAT_READ_OK    = 3'd3;
   localparam logic [2:0] STAT_READ_EMPTY = 3'd4;
   localparam logic [2:0] STAT_CLEARED    = 3'd5;
   localparam logic [2:0] STAT_IGNORED    = 3'd6;

   // Configuration register indexes
   localparam logic REG_RECORDING_ENABLED = 1'b0;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] transition_id;
      logic [15:0] fire_increment;
      logic [4:0]  entry_index;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [4:0]  slot;
      logic [15:0] key;
      logic [15:0] instances;
      logic [31:0] total_fires;
      logic [31:0] average_fires;
      logic [5:0]  used_count;
   } rsp_type;

   // One stored table entry
   typedef struct packed {
      logic [15:0] key;
      logic [15:0] instances;
      logic [31:0] total;
   } entry_type;

   // Divider status toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_UPDATE,
      ST_INSERT,
      ST_RDWAIT,
      ST_DIVSTART,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

/* rtl/core/ket_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ket_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 32,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* rtl/core/ket_div.sv */
// Restoring divider, 32-bit dividend by 16-bit divisor, one quotient bit per cycle.
`default_nettype none

module ket_div (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic [31:0]             dividend,
   input  wire logic [15:0]             divisor,
   output ket_pkg::div_status_type      status,
   output logic      [31:0]             quotient
);
   import ket_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] quo_ff, quo_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] dsr_ff, dsr_in;
   logic [16:0] shifted;
   logic [16:0] diff;
   logic        ge;

   // Shift in the next dividend bit and trial-subtract
   assign shifted = {rem_ff, quo_ff[31]};
   assign diff    = shifted - {1'b0, dsr_ff};
   assign ge      = (shifted >= {1'b0, dsr_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[30:0], ge};
         rem_in = ge ? diff[15:0] : shifted[15:0];
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

`default_nettype wire

/* rtl/core/keyed_event_count_table_unit.sv */
// Top level of the keyed event count table: sequencer, entry RAM and shared divider.
//
// Input words (req_*) carry a kind: record, read or clear. While recording
// is enabled, a record word searches the occupied entries in insertion
// order, one entry per cycle through the entry RAM read port, then updates
// or appends an entry, or drops the word on a full table. A read word
// fetches one entry. Updated and read entries have their average computed
// by a bit-serial divider.
// Each input word yields exactly one result word on rsp_*.
// One word is handled at a time and req_ready is high only while the
// sequencer is idle, so the next word can be accepted in the same cycle
// in which the result of the last one is raised.
// A finished result sits in the output register; the next word is
// accepted meanwhile and holds in its last step while rsp_ready is low.
// Reset empties the table (occupied count to zero) and sets recording
// enabled. The APB register at address 0, bit 0, enables recording.
`default_nettype none

module keyed_event_count_table_unit #(
   parameter int unsigned TABLE_ENTRIES = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire ket_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output ket_pkg::rsp_type       rsp_data,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [2:0]        paddr,
   input  wire logic [31:0]       pwdata,
   output logic      [31:0]       prdata,
   output logic                   pready
);
   import ket_pkg::*;

   localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
   localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int unsigned CMP_W = (CNT_W > 5) ? CNT_W : 5;
   localparam int unsigned ENT_W = $bits(entry_type);

   state_type        state_ff, state_in;
   req_type          item_ff, item_in;
   logic [CNT_W-1:0] occ_ff, occ_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic             pend_ff, pend_in;
   logic [IDX_W-1:0] pend_idx_ff, pend_idx_in;
   entry_type        hit_ff, hit_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   rsp_type          res_ff, res_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             enabled_ff;

   logic             ram_we;
   logic [IDX_W-1:0] ram_waddr;
   entry_type        ram_wdata;
   logic [IDX_W-1:0] ram_raddr;
   entry_type        ram_rdata;

   logic             div_start;
   div_status_type   div_st;
   logic [31:0]      div_quotient;

   logic             accept;
   logic             out_free;
   logic             key_match;
   logic             scan_more;
   logic             table_full;
   logic             read_in_range;
   logic [15:0]      inst_next;
   logic [32:0]      total_sum;
   logic [31:0]      total_next;

   // Entry storage
   ket_ram #(
      .WIDTH(ENT_W),
      .DEPTH(TABLE_ENTRIES)
   ) u_ram (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   // Shared divider for averages
   ket_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(res_ff.total_fires),
      .divisor (res_ff.instances),
      .status  (div_st),
      .quotient(div_quotient)
   );

   // Configuration port
   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_RECORDING_ENABLED) ? {31'd0, enabled_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b1;
      end else if (psel && penable && pwrite && pready
                   && paddr[2] == REG_RECORDING_ENABLED) begin
         enabled_ff <= pwdata[0];
      end
   end

   // Handshake and compare terms
   assign req_ready     = (state_ff == ST_IDLE);
   assign accept        = req_valid && req_ready;
   assign out_free      = !rsp_valid_ff || rsp_ready;
   assign key_match     = pend_ff && (ram_rdata.key == item_ff.transition_id);
   assign scan_more     = (scan_ff < occ_ff);
   assign table_full    = (occ_ff == CNT_W'(TABLE_ENTRIES));
   assign read_in_range = (CMP_W'(req_data.entry_index) < CMP_W'(occ_ff));

   // Saturating counter updates for a hit
   assign inst_next  = (hit_ff.instances == 16'hFFFF) ? 16'hFFFF : hit_ff.instances + 16'd1;
   assign total_sum  = {1'b0, hit_ff.total} + {17'd0, item_ff.fire_increment};
   assign total_next = total_sum[32] ? 32'hFFFF_FFFF : total_sum[31:0];

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.kind)
                  KIND_RECORD: begin
                     if (!enabled_ff) begin
                        state_in = ST_FINISH;
                     end else if (occ_ff == '0) begin
                        state_in = ST_INSERT;
                     end else begin
                        state_in = ST_SEARCH;
                     end
                  end
                  KIND_READ: state_in = read_in_range ? ST_RDWAIT : ST_FINISH;
                  default:   state_in = ST_FINISH;
               endcase
            end
         end
         ST_SEARCH: begin
            if (key_match) begin
               state_in = ST_UPDATE;
            end else if (!scan_more && !pend_ff) begin
               state_in = table_full ? ST_FINISH : ST_INSERT;
            end
         end
         ST_UPDATE:   state_in = ST_DIVSTART;
         ST_INSERT:   state_in = ST_FINISH;
         ST_RDWAIT:   state_in = ST_DIVSTART;
         ST_DIVSTART: state_in = ST_DIVIDE;
         ST_DIVIDE: begin
            if (div_st.done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and control outputs
   always_comb begin
      item_in      = item_ff;
      occ_in       = occ_ff;
      scan_in      = scan_ff;
      pend_in      = pend_ff;
      pend_idx_in  = pend_idx_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ram_we       = 1'b0;
      ram_waddr    = hit_idx_ff;
      ram_wdata    = hit_ff;
      ram_raddr    = scan_ff[IDX_W-1:0];
      div_start    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            ram_raddr = IDX_W'(req_data.entry_index);
            if (accept) begin
               item_in = req_data;
               scan_in = '0;
               pend_in = 1'b0;
               res_in  = '0;
               case (req_data.kind)
                  KIND_RECORD: begin
                     if (!enabled_ff) begin
                        res_in.status = STAT_IGNORED;
                     end
                  end
                  KIND_READ: begin
                     res_in.slot = req_data.entry_index;
                     if (!read_in_range) begin
                        res_in.status = STAT_READ_EMPTY;
                     end
                  end
                  KIND_CLEAR: begin
                     occ_in        = '0;
                     res_in.status = STAT_CLEARED;
                  end
                  default: res_in.status = STAT_IGNORED;
               endcase
            end
         end
         ST_SEARCH: begin
            // Compare the word read last cycle while fetching the next one
            if (key_match) begin
               hit_in     = ram_rdata;
               hit_idx_in = pend_idx_ff;
            end else if (scan_more) begin
               pend_in     = 1'b1;
               pend_idx_in = scan_ff[IDX_W-1:0];
               scan_in     = scan_ff + CNT_W'(1);
            end else if (pend_ff) begin
               pend_in = 1'b0;
            end else if (table_full) begin
               res_in.status = STAT_FULL;
               res_in.key    = item_ff.transition_id;
            end
         end
         ST_UPDATE: begin
            ram_we              = 1'b1;
            ram_waddr           = hit_idx_ff;
            ram_wdata.key       = hit_ff.key;
            ram_wdata.instances = inst_next;
            ram_wdata.total     = total_next;
            res_in.status       = STAT_UPDATED;
            res_in.slot         = 5'(hit_idx_ff);
            res_in.key          = hit_ff.key;
            res_in.instances    = inst_next;
            res_in.total_fires  = total_next;
         end
         ST_INSERT: begin
            // Append at the end of the occupied range
            ram_we               = 1'b1;
            ram_waddr            = occ_ff[IDX_W-1:0];
            ram_wdata.key        = item_ff.transition_id;
            ram_wdata.instances  = 16'd1;
            ram_wdata.total      = {16'd0, item_ff.fire_increment};
            occ_in               = occ_ff + CNT_W'(1);
            res_in.status        = STAT_INSERTED;
            res_in.slot          = 5'(occ_ff);
            res_in.key           = item_ff.transition_id;
            res_in.instances     = 16'd1;
            res_in.total_fires   = {16'd0, item_ff.fire_increment};
            res_in.average_fires = {16'd0, item_ff.fire_increment};
         end
         ST_RDWAIT: begin
            res_in.status      = STAT_READ_OK;
            res_in.key         = ram_rdata.key;
            res_in.instances   = ram_rdata.instances;
            res_in.total_fires = ram_rdata.total;
         end
         ST_DIVSTART: begin
            div_start = 1'b1;
         end
         ST_DIVIDE: begin
            if (div_st.done) begin
               res_in.average_fires = (res_ff.instances == 16'd0) ? 32'd0 : div_quotient;
            end
         end
         ST_FINISH: begin
            // Hand the result to the output register once it is free
            if (out_free) begin
               rsp_in            = res_ff;
               rsp_in.used_count = 6'(occ_ff);
               rsp_valid_in      = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff     <= item_in;
      scan_ff     <= scan_in;
      pend_idx_ff <= pend_idx_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Checks
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CNT_W'(TABLE_ENTRIES))
      else $error("occupied count beyond table size");

   a_idle_div: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !div_st.busy)
      else $error("divider busy while accepting a word");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INSERT) |=> (occ_ff == $past(occ_ff) + CNT_W'(1)))
      else $error("insert did not grow the table");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FINISH))
      else $error("result raised outside the finish step");

endmodule

`default_nettype wire
